>>> rtl/core/wscp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscp_pkg: shared definitions for the weighted-sum complex phasor
// Widths, reset values, sequencer states, CORDIC angle table and the
// round-and-saturate helper used on the final products.
// ----------------------------------------------------------------------------
package wscp_pkg;

  localparam int MAX_TERMS_DEF    = 64;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ACC_W      = 48;
  localparam int PACC_W     = 58;   // phase product kept modulo 2^58
  localparam int ANGLE_W    = 32;
  localparam int CORDIC_W   = 34;
  localparam int STEP_IDX_W = 5;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int RES_W      = 17;

  localparam logic signed [31:0]         PHASE_SCALE_RESET = -32'sd8589935;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN       = 34'sd652032874;
  localparam logic [1:0]                 LAST_PART         = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TACC,
    ST_PMUL,
    ST_PACC,
    ST_CLOAD,
    ST_CSTEP,
    ST_MMUL_RE,
    ST_MMUL_IM,
    ST_MRND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  load;
    logic                  step;
    logic [STEP_IDX_W-1:0] idx;
  } cordic_ctrl_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] i);
    logic [ANGLE_W-1:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 times Q1.15 mask back to Q1.15: round half up, clamp to +-one
  function automatic logic signed [RES_W-1:0] round_sat_q15(
      input logic signed [MUL_P_W-1:0] p);
    logic signed [MUL_P_W-1:0]  s;
    logic signed [MUL_P_W-31:0] r;
    logic signed [RES_W-1:0]    q;
    s = p + $signed({{(MUL_P_W-30){1'b0}}, 1'b1, 29'd0});
    r = s[MUL_P_W-1:30];
    if (r > (MUL_P_W-30)'(32768)) begin
      q = 17'sd32768;
    end else if (r < -(MUL_P_W-30)'(32768)) begin
      q = -17'sd32768;
    end else begin
      q = r[RES_W-1:0];
    end
    return q;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/wscp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wscp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/wscp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscp_mul: shared signed multiplier
// 34 x 17 signed multiply with the product registered; used for the term
// products, the phase partial products and the mask scaling.
// ----------------------------------------------------------------------------
module wscp_mul import wscp_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/wscp_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wscp_cordic: iterative CORDIC rotator
// Folds the angle into the right half-plane on load, then does one
// rotation step per cycle while step is set; outputs cos and sin in Q2.30.
// ----------------------------------------------------------------------------
module wscp_cordic import wscp_pkg::*; (
  input  logic                       clk,
  input  cordic_ctrl_t               ctrl,
  input  logic [ANGLE_W-1:0]         angle,
  output logic signed [CORDIC_W-1:0] cos_out,
  output logic signed [CORDIC_W-1:0] sin_out
);

  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
  logic signed [CORDIC_W-1:0] dx, dy, atan_ext;
  logic                       flip, flip_next;
  logic [ANGLE_W-1:0]         a_rot;
  logic                       half_flip;

  always_comb begin
    half_flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    a_rot     = angle ^ {half_flip, {(ANGLE_W-1){1'b0}}};
    dx        = y >>> ctrl.idx;
    dy        = x >>> ctrl.idx;
    atan_ext  = $signed({{(CORDIC_W-ANGLE_W){1'b0}}, atan_turn(ctrl.idx)});
    x_next    = x;
    y_next    = y;
    z_next    = z;
    flip_next = flip;
    if (ctrl.load) begin
      // second and third quadrants: rotate by half a turn, negate at the end
      flip_next = half_flip;
      x_next    = CORDIC_GAIN;
      y_next    = '0;
      z_next    = CORDIC_W'($signed(a_rot));
    end else if (ctrl.step) begin
      if (!z[CORDIC_W-1]) begin
        x_next = x - dx;
        y_next = y + dy;
        z_next = z - atan_ext;
      end else begin
        x_next = x + dx;
        y_next = y - dy;
        z_next = z + atan_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    x    <= x_next;
    y    <= y_next;
    z    <= z_next;
    flip <= flip_next;
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule
`default_nettype wire

>>> rtl/core/weighted_sum_complex_phasor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_sum_complex_phasor: weighted sum of basis terms to a masked phasor
// Coefficient store, 48-bit term accumulator, phase scaling and CORDIC
// cos/sin under a small sequencer; all products use one shared multiplier.
// ----------------------------------------------------------------------------
// Load items write the coefficient store. A term item that is not last goes
// through store read, multiply and accumulate. A last term goes on with three
// partial products of the 48-bit sum with phase_scale on the shared 34x17
// multiplier, one CORDIC step per cycle, and two mask products; it then
// waits only if the previous result is still held in the output register.
// No item is taken while a term is in work. The coefficient store is cleared
// by reset through per-entry valid bits, so no clearing pass is needed.
module weighted_sum_complex_phasor import wscp_pkg::*; #(
  parameter int MAX_TERMS    = MAX_TERMS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [5:0]              term_index,
  input  logic signed [15:0]      term_value,
  input  logic [15:0]             mask_value,
  input  logic                    last_term,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] real_part,
  output logic signed [RES_W-1:0] imag_part,
  input  logic                    cfg_write_en,
  input  logic signed [31:0]      cfg_write_data
);

  localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t state, state_next;

  logic                in_accept;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_range;
  logic                ram_we;
  logic [15:0]         coef_rdata;
  logic [MAX_TERMS-1:0] coef_valid;

  logic signed [15:0]  basis;
  logic [15:0]         mask;
  logic                last_flag;
  logic                coef_ok;
  logic signed [15:0]  coef;

  logic signed [31:0]  phase_scale;
  logic [ACC_W-1:0]    acc;
  logic [PACC_W-1:0]   pacc;
  logic [PACC_W-1:0]   pp_ext, pp_shift;
  logic [1:0]          part;
  logic [STEP_W-1:0]   step;
  logic signed [MUL_B_W-1:0] chunk;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  cordic_ctrl_t               cordic_ctrl;
  logic signed [CORDIC_W-1:0] cos_val, sin_val;

  logic signed [RES_W-1:0] res_re, res_im;
  logic                    out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_addr   = ADDR_W'(term_index);
  assign in_range  = (32'(term_index) < MAX_TERMS);
  assign ram_we    = in_accept && !req_type && in_range;
  assign out_free  = !out_valid || !out_stall;
  assign coef      = coef_ok ? $signed(coef_rdata) : 16'sd0;

  wscp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_addr),
    .wdata (term_value),
    .raddr (in_addr),
    .rdata (coef_rdata)
  );

  wscp_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  wscp_cordic u_cordic (
    .clk     (clk),
    .ctrl    (cordic_ctrl),
    .angle   (pacc[PACC_W-1:PACC_W-ANGLE_W]),
    .cos_out (cos_val),
    .sin_out (sin_val)
  );

  // 16-bit slices of the sum; the top one carries the sign
  always_comb begin
    case (part)
      2'd0:    chunk = $signed({1'b0, acc[15:0]});
      2'd1:    chunk = $signed({1'b0, acc[31:16]});
      default: chunk = $signed({acc[ACC_W-1], acc[ACC_W-1:32]});
    endcase
  end

  always_comb begin
    pp_ext = PACC_W'(mul_p);
    case (part)
      2'd0:    pp_shift = pp_ext;
      2'd1:    pp_shift = {pp_ext[PACC_W-17:0], 16'd0};
      default: pp_shift = {pp_ext[PACC_W-33:0], 32'd0};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid && req_type) state_next = ST_TMUL;
      ST_TMUL:    state_next = ST_TACC;
      ST_TACC:    state_next = last_flag ? ST_PMUL : ST_IDLE;
      ST_PMUL:    state_next = ST_PACC;
      ST_PACC:    state_next = (part == LAST_PART) ? ST_CLOAD : ST_PMUL;
      ST_CLOAD:   state_next = ST_CSTEP;
      ST_CSTEP:   if (step == LAST_STEP) state_next = ST_MMUL_RE;
      ST_MMUL_RE: state_next = ST_MMUL_IM;
      ST_MMUL_IM: state_next = ST_MRND;
      ST_MRND:    state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall         = 1'b1;
    mul_en           = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    cordic_ctrl.load = 1'b0;
    cordic_ctrl.step = 1'b0;
    cordic_ctrl.idx  = STEP_IDX_W'(step);
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_TMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(coef);
        mul_b  = MUL_B_W'(basis);
      end
      ST_PMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(phase_scale);
        mul_b  = chunk;
      end
      ST_CLOAD: cordic_ctrl.load = 1'b1;
      ST_CSTEP: cordic_ctrl.step = 1'b1;
      ST_MMUL_RE: begin
        mul_en = 1'b1;
        mul_a  = cos_val;
        mul_b  = $signed({1'b0, mask});
      end
      ST_MMUL_IM: begin
        mul_en = 1'b1;
        mul_a  = sin_val;
        mul_b  = $signed({1'b0, mask});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      coef_valid  <= '0;
      acc         <= '0;
      phase_scale <= PHASE_SCALE_RESET;
      out_valid   <= 1'b0;
      part        <= '0;
      step        <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        phase_scale <= cfg_write_data;
      end
      if (ram_we) begin
        coef_valid[in_addr] <= 1'b1;
      end
      if (state == ST_TACC) begin
        acc  <= acc + mul_p[ACC_W-1:0];
        part <= '0;
      end
      if (state == ST_PACC) begin
        part <= part + 2'd1;
        // sum fully consumed: drop it for the next point
        if (part == LAST_PART) begin
          acc <= '0;
        end
      end
      if (state == ST_CLOAD) begin
        step <= '0;
      end else if (state == ST_CSTEP) begin
        step <= step + 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      basis     <= term_value;
      mask      <= mask_value;
      last_flag <= last_term;
      coef_ok   <= in_range && coef_valid[in_addr];
    end
    if (state == ST_TACC) begin
      pacc <= '0;
    end else if (state == ST_PACC) begin
      pacc <= pacc + pp_shift;
    end
    if (state == ST_MMUL_IM) begin
      res_re <= round_sat_q15(mul_p);
    end
    if (state == ST_MRND) begin
      res_im <= round_sat_q15(mul_p);
    end
    if (state == ST_OUT && out_free) begin
      real_part <= res_re;
      imag_part <= res_im;
    end
  end

  a_load_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !req_type) |=> $stable(acc))
    else $error("load item changed the accumulator");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PACC && part == LAST_PART) |=> (acc == '0))
    else $error("accumulator not cleared after phase product");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CSTEP) |-> (32'(step) < CORDIC_STEPS))
    else $error("CORDIC step count out of range");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not posted to output register");

endmodule
`default_nettype wire
